FILE: rtl/mkd_pkg.sv
// Package for the Morse key decoder: widths, register indexes and the
// letter-code lookup. No dependencies; imported by every rtl module.

package mkd_pkg;

   localparam int COUNT_WIDTH = 24;
   localparam int REG_WIDTH   = 24;
   localparam int CMP_WIDTH   = ((COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH) + 1;
   localparam int CODE_WIDTH  = 8;
   localparam int CHAR_WIDTH  = 8;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DOT_TICKS   = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DASH_TICKS  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPACE_TICKS = 2'd2;

   localparam logic [REG_WIDTH-1:0] DOT_TICKS_RESET   = REG_WIDTH'(100);
   localparam logic [REG_WIDTH-1:0] DASH_TICKS_RESET  = REG_WIDTH'(300);
   localparam logic [REG_WIDTH-1:0] SPACE_TICKS_RESET = REG_WIDTH'(700);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // marker bit only: no element held; also decodes to a space
   localparam logic [CODE_WIDTH-1:0] CODE_EMPTY = 8'h01;
   localparam logic [CHAR_WIDTH-1:0] SPACE_CHAR = 8'h20;

   typedef struct packed {
      logic                  valid;
      logic [CODE_WIDTH-1:0] code;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Letter code (leading marker bit, dot = 0, dash = 1) to ASCII.
   function automatic logic [CHAR_WIDTH-1:0] decode_code(input logic [CODE_WIDTH-1:0] code);
      logic [CHAR_WIDTH-1:0] ch;
      case (code)
         8'd2:    ch = "e";
         8'd3:    ch = "t";
         8'd4:    ch = "i";
         8'd5:    ch = "a";
         8'd6:    ch = "n";
         8'd7:    ch = "m";
         8'd8:    ch = "s";
         8'd9:    ch = "u";
         8'd10:   ch = "r";
         8'd11:   ch = "w";
         8'd12:   ch = "d";
         8'd13:   ch = "k";
         8'd14:   ch = "g";
         8'd15:   ch = "o";
         8'd16:   ch = "h";
         8'd17:   ch = "v";
         8'd18:   ch = "f";
         8'd20:   ch = "l";
         8'd22:   ch = "p";
         8'd23:   ch = "j";
         8'd24:   ch = "b";
         8'd25:   ch = "x";
         8'd26:   ch = "c";
         8'd27:   ch = "y";
         8'd28:   ch = "z";
         8'd29:   ch = "q";
         8'd32:   ch = "5";
         8'd33:   ch = "4";
         8'd35:   ch = "3";
         8'd39:   ch = "2";
         8'd47:   ch = "1";
         8'd48:   ch = "6";
         8'd56:   ch = "7";
         8'd60:   ch = "8";
         8'd62:   ch = "9";
         8'd63:   ch = "0";
         default: ch = SPACE_CHAR;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/morse_key_decoder.sv
// Top level of the Morse key decoder: front end, request queue, back end.
// Depends on mkd_pkg, mkd_front, mkd_queue and mkd_back.
//
// Usage:
//  - req_*: one key sample per request (req_key_pressed = 1 while touched),
//    valid/ready. A request is taken every cycle while req_ready is high.
//  - rsp_*: one decoded character per response (lower-case letter, digit or
//    space 0x20), valid/ready. Most samples give no response; a release that
//    classifies as a word space, or the gap sample that closes a letter,
//    gives exactly one.
//  - csr_*: write-only thresholds (dot, dash, space ticks), written while
//    csr_write_enable is high; unknown indexes are dropped.
// With the response register free, a request's code is written into the queue
// at the edge that accepts the request and is then looked up into the response
// register, which drives rsp_*.
// Throughput: one sample per cycle while req_ready is high. The front end
// computes counter updates and classification combinationally; the 4-entry
// queue decouples it from the response register, so req_ready only drops when
// the queue is full, i.e. when rsp_ready is held low long enough to back it up.
// Reset (synchronous): thresholds go to 100/300/700, counters clear, no
// element held, queue and response register empty. No clearing pass.

module morse_key_decoder
   import mkd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [REG_WIDTH-1:0]     csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_key_pressed,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CHAR_WIDTH-1:0]    rsp_char_code
);

   push_type              push;
   queue_status_type      queue_status;
   logic                  pop;
   logic [CODE_WIDTH-1:0] head_code;

   // classify and assemble letter codes
   mkd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_pressed  (req_key_pressed),
      .queue_status     (queue_status),
      .push             (push)
   );

   // finished codes; a word space travels as the marker-only code
   mkd_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .pop          (pop),
      .head_code    (head_code),
      .queue_status (queue_status)
   );

   // lookup and response register
   mkd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_code     (head_code),
      .queue_status  (queue_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code)
   );

endmodule

FILE: rtl/mkd_front.sv
// Front end of the Morse key decoder: threshold registers, press/gap
// counters, element classification and letter assembly. Uses mkd_pkg.

module mkd_front
   import mkd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [REG_WIDTH-1:0]     csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_key_pressed,
   input  queue_status_type         queue_status,
   output push_type                 push
);

   logic [REG_WIDTH-1:0]   dot_ticks_ff, dot_ticks_in;
   logic [REG_WIDTH-1:0]   dash_ticks_ff, dash_ticks_in;
   logic [REG_WIDTH-1:0]   space_ticks_ff, space_ticks_in;
   logic [COUNT_WIDTH-1:0] press_count_ff, press_count_in;
   logic [COUNT_WIDTH-1:0] gap_count_ff, gap_count_in;
   logic                   in_press_ff, in_press_in;
   logic [CODE_WIDTH-1:0]  symbol_code_ff, symbol_code_in;

   logic                   accept;
   logic [CMP_WIDTH-1:0]   n_ext, n_dbl, dot_ext, dash_ext, space_ext;
   logic [CMP_WIDTH-1:0]   dot_dash_sum, dash_space_sum;
   logic                   is_space, is_dash;
   logic [COUNT_WIDTH-1:0] gap_next;

   // every accepted sample may end a letter, so hold off while the queue is full
   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      dot_ticks_in   = dot_ticks_ff;
      dash_ticks_in  = dash_ticks_ff;
      space_ticks_in = space_ticks_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DOT_TICKS:   dot_ticks_in   = csr_wdata;
            CSR_DASH_TICKS:  dash_ticks_in  = csr_wdata;
            CSR_SPACE_TICKS: space_ticks_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Nearest-threshold test: for d <= n < s, n - d > s - n is 2n > d + s.
   always_comb begin
      n_ext          = CMP_WIDTH'(press_count_ff);
      n_dbl          = n_ext << 1;
      dot_ext        = CMP_WIDTH'(dot_ticks_ff);
      dash_ext       = CMP_WIDTH'(dash_ticks_ff);
      space_ext      = CMP_WIDTH'(space_ticks_ff);
      dot_dash_sum   = dot_ext + dash_ext;
      dash_space_sum = dash_ext + space_ext;
      is_space = (n_ext >= space_ext) || ((n_ext >= dash_ext) && (n_dbl > dash_space_sum));
      is_dash  = (n_ext >= dash_ext)  || ((n_ext >= dot_ext)  && (n_dbl > dot_dash_sum));
   end

   assign gap_next = (gap_count_ff != COUNT_MAX) ? gap_count_ff + 1'b1 : gap_count_ff;

   always_comb begin
      press_count_in = press_count_ff;
      gap_count_in   = gap_count_ff;
      in_press_in    = in_press_ff;
      symbol_code_in = symbol_code_ff;
      push.valid     = 1'b0;
      push.code      = symbol_code_ff;
      if (accept) begin
         if (req_key_pressed) begin
            in_press_in  = 1'b1;
            gap_count_in = '0;
            if (press_count_ff != COUNT_MAX) begin
               press_count_in = press_count_ff + 1'b1;
            end
         end else if (in_press_ff) begin
            press_count_in = '0;
            in_press_in    = 1'b0;
            if (is_space) begin
               // word space: marker-only code decodes to a space
               gap_count_in   = '0;
               symbol_code_in = CODE_EMPTY;
               push.valid     = 1'b1;
               push.code      = CODE_EMPTY;
            end else if (!symbol_code_ff[CODE_WIDTH-1]) begin
               symbol_code_in = {symbol_code_ff[CODE_WIDTH-2:0], is_dash};
            end
         end else if (symbol_code_ff != CODE_EMPTY) begin
            if (CMP_WIDTH'(gap_next) > dash_ext) begin
               push.valid     = 1'b1;
               symbol_code_in = CODE_EMPTY;
               gap_count_in   = '0;
            end else begin
               gap_count_in = gap_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ticks_ff   <= DOT_TICKS_RESET;
         dash_ticks_ff  <= DASH_TICKS_RESET;
         space_ticks_ff <= SPACE_TICKS_RESET;
         press_count_ff <= '0;
         gap_count_ff   <= '0;
         in_press_ff    <= 1'b0;
         symbol_code_ff <= CODE_EMPTY;
      end else begin
         dot_ticks_ff   <= dot_ticks_in;
         dash_ticks_ff  <= dash_ticks_in;
         space_ticks_ff <= space_ticks_in;
         press_count_ff <= press_count_in;
         gap_count_ff   <= gap_count_in;
         in_press_ff    <= in_press_in;
         symbol_code_ff <= symbol_code_in;
      end
   end

   a_code_marker: assert property (@(posedge clock) disable iff (reset)
      symbol_code_ff != '0)
      else $error("letter code lost its marker bit");

   a_press_no_gap: assert property (@(posedge clock) disable iff (reset)
      in_press_ff |-> gap_count_ff == '0)
      else $error("gap count running during a press");

   a_count_in_press: assert property (@(posedge clock) disable iff (reset)
      (press_count_ff != '0) |-> in_press_ff)
      else $error("press count held outside a press");

endmodule

FILE: rtl/mkd_queue.sv
// Small request queue between the decoder front and back ends.
// Holds letter codes; uses mkd_pkg.

module mkd_queue
   import mkd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  push_type              push,
   input  logic                  pop,
   output logic [CODE_WIDTH-1:0] head_code,
   output queue_status_type      queue_status
);

   logic [CODE_WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign queue_status.full  = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign do_push   = push.valid && !queue_status.full;
   assign do_pop    = pop && !queue_status.empty;
   assign head_code = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QPTR_WIDTH'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPTR_WIDTH'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count over depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && queue_status.full))
      else $error("push into full queue");

endmodule

FILE: rtl/mkd_back.sv
// Back end of the Morse key decoder: pops letter codes, looks them up and
// holds the character in the response register. Uses mkd_pkg.

module mkd_back
   import mkd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CODE_WIDTH-1:0] head_code,
   input  queue_status_type      queue_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_WIDTH-1:0] rsp_char_code
);

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0] rsp_char_ff, rsp_char_in;
   logic                  load;

   assign load = !rsp_valid_ff || rsp_ready;
   assign pop  = load && !queue_status.empty;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      if (load) begin
         rsp_valid_in = !queue_status.empty;
         rsp_char_in  = decode_code(head_code);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;

endmodule
